// File: hw/rtl/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and constants of the cubic B-spline curve tessellator.
// ----------------------------------------------------------------------------
package bct_pkg;

    localparam int COORD_BITS        = 16;
    localparam int MAX_STEPS_DEFAULT = 63;
    localparam int STEPS_WIDTH       = 6;
    localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = 6'd10;

    // APB register file: one 32-bit register, word index in paddr[2]
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 3;
    localparam logic REG_STEPS = 1'b0;

    localparam int SEG_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    // four control points of one segment, p0 oldest
    typedef struct packed {
        vec3_t p0;
        vec3_t p1;
        vec3_t p2;
        vec3_t p3;
    } segment_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   end_of_curve;
    } point_in_t;

    typedef struct packed {
        coord_t curve_x;
        coord_t curve_y;
        coord_t curve_z;
        logic   segment_last;
    } curve_out_t;

    // two's complement <-> offset binary
    function automatic logic [COORD_BITS-1:0] flip_sign(input logic [COORD_BITS-1:0] v);
        return {~v[COORD_BITS-1], v[COORD_BITS-2:0]};
    endfunction

endpackage

// File: hw/rtl/bct_fifo.sv
// ----------------------------------------------------------------------------
// bct_fifo
// Small register FIFO with full/empty flags.
// ----------------------------------------------------------------------------
module bct_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [Width-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [Width-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    logic [Width-1:0] mem_reg [Depth];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/bct_front.sv
// ----------------------------------------------------------------------------
// bct_front
// Control point window; issues a segment once four points are held.
// ----------------------------------------------------------------------------
module bct_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  bct_pkg::point_in_t  point,
    output logic                seg_push,
    output bct_pkg::segment_t   seg_data,
    input  logic                seg_full
);

    import bct_pkg::*;

    vec3_t       win_reg [3];
    logic [1:0]  held_reg;
    vec3_t       cur;
    logic        accept;

    assign full   = seg_full;
    assign accept = push & ~seg_full;
    assign cur    = '{x: point.point_x, y: point.point_y, z: point.point_z};

    assign seg_push = accept & (held_reg == 2'd3);
    assign seg_data = '{p0: win_reg[0], p1: win_reg[1], p2: win_reg[2], p3: cur};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (accept)
        begin
            if (point.end_of_curve)
            begin
                held_reg <= '0;
            end
            else if (held_reg != 2'd3)
            begin
                held_reg <= held_reg + 1'b1;
            end
        end
    end

    // window contents only matter once held_reg reaches three
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= cur;
        end
    end

endmodule

// File: hw/rtl/bct_back.sv
// ----------------------------------------------------------------------------
// bct_back
// Segment evaluator: weights, multiply-accumulate and rounding divide.
// ----------------------------------------------------------------------------
module bct_back #(
    parameter int MaxSteps = bct_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [bct_pkg::STEPS_WIDTH-1:0]      steps,
    input  logic                                 seg_empty,
    output logic                                 seg_pop,
    input  bct_pkg::segment_t                    seg_data,
    output logic                                 res_push,
    output bct_pkg::curve_out_t                  res_data,
    input  logic                                 res_full
);

    import bct_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int SW  = $clog2(MaxSteps + 1);
    localparam int WW  = $clog2(6 * MaxSteps * MaxSteps * MaxSteps + 1);
    localparam int IW  = 3 * SW + 4;
    localparam int AW  = WW + CB;
    localparam int DCW = $clog2(CB);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SQR  = 8'b0000_0010,
        ST_CUBE = 8'b0000_0100,
        ST_WGT  = 8'b0000_1000,
        ST_MAC  = 8'b0001_0000,
        ST_NUM  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [SW-1:0]   n_reg, k_reg, n_clamp, m;
    logic [2*SW-1:0] k2_reg, n2_reg, m2_reg;
    logic [3*SW-1:0] k3_reg, n3_reg, m3_reg, k2n_reg, kn2_reg;
    logic [1:0]      mac_cnt_reg;
    logic [DCW-1:0]  div_cnt_reg;

    logic [3:0][2:0][CB-1:0] u_reg;
    logic [3:0][WW-1:0]      w_reg;
    logic [WW-1:0]           d_reg;
    logic [WW:0]             d2;
    logic [2:0][AW-1:0]      acc_reg;
    logic [2:0][WW:0]        rem_reg;
    logic [2:0][CB-1:0]      low_reg;
    logic [2:0][CB-1:0]      quo_reg;

    logic [IW-1:0]      w1_full, w2_full;
    logic [2:0][AW:0]   num;
    logic [2:0][WW+1:0] trial;
    logic [2:0]         ge;
    logic [2:0][WW:0]   rem_next;
    logic               last_k;

    // zero steps behaves as one, large values saturate
    always_comb
    begin
        if (steps == '0)
        begin
            n_clamp = SW'(1);
        end
        else if (steps > STEPS_WIDTH'(MaxSteps))
        begin
            n_clamp = SW'(MaxSteps);
        end
        else
        begin
            n_clamp = SW'(steps);
        end
    end

    assign m      = n_reg - k_reg;
    assign last_k = (k_reg == n_reg);
    assign d2     = {d_reg, 1'b0};

    // modular arithmetic: the true weights are non-negative and fit
    assign w1_full = IW'(3 * IW'(k3_reg) + 4 * IW'(n3_reg) - 6 * IW'(k2n_reg));
    assign w2_full = IW'(3 * IW'(k2n_reg) + 3 * IW'(kn2_reg) + IW'(n3_reg)
                         - 3 * IW'(k3_reg));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            num[a]      = {acc_reg[a], 1'b0} + (AW + 1)'(d_reg);
            trial[a]    = {rem_reg[a], low_reg[a][CB-1]};
            ge[a]       = (trial[a] >= {1'b0, d2});
            rem_next[a] = ge[a] ? (WW + 1)'(trial[a] - {1'b0, d2}) : (WW + 1)'(trial[a]);
        end
    end

    assign seg_pop  = (state_reg == ST_IDLE) & ~seg_empty;
    assign res_push = (state_reg == ST_OUT) & ~res_full;

    assign res_data = '{
        curve_x:      coord_t'(flip_sign(quo_reg[0])),
        curve_y:      coord_t'(flip_sign(quo_reg[1])),
        curve_z:      coord_t'(flip_sign(quo_reg[2])),
        segment_last: last_k
    };

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!seg_empty) state_next = ST_SQR;
            ST_SQR:  state_next = ST_CUBE;
            ST_CUBE: state_next = ST_WGT;
            ST_WGT:  state_next = ST_MAC;
            ST_MAC:  if (mac_cnt_reg == 2'd3) state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:  if (div_cnt_reg == DCW'(CB - 1)) state_next = ST_OUT;
            ST_OUT:
            begin
                if (!res_full)
                begin
                    state_next = last_k ? ST_IDLE : ST_SQR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            k_reg       <= '0;
            mac_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (seg_pop)
            begin
                n_reg <= n_clamp;
                k_reg <= '0;
            end
            if (res_push && !last_k)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == ST_WGT)
            begin
                mac_cnt_reg <= '0;
            end
            else if (state_reg == ST_MAC)
            begin
                mac_cnt_reg <= mac_cnt_reg + 1'b1;
            end
            if (state_reg == ST_NUM)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!seg_empty)
                begin
                    u_reg[0] <= {flip_sign(seg_data.p0.z), flip_sign(seg_data.p0.y),
                                 flip_sign(seg_data.p0.x)};
                    u_reg[1] <= {flip_sign(seg_data.p1.z), flip_sign(seg_data.p1.y),
                                 flip_sign(seg_data.p1.x)};
                    u_reg[2] <= {flip_sign(seg_data.p2.z), flip_sign(seg_data.p2.y),
                                 flip_sign(seg_data.p2.x)};
                    u_reg[3] <= {flip_sign(seg_data.p3.z), flip_sign(seg_data.p3.y),
                                 flip_sign(seg_data.p3.x)};
                end
            end
            ST_SQR:
            begin
                k2_reg <= (2 * SW)'(k_reg) * (2 * SW)'(k_reg);
                n2_reg <= (2 * SW)'(n_reg) * (2 * SW)'(n_reg);
                m2_reg <= (2 * SW)'(m) * (2 * SW)'(m);
            end
            ST_CUBE:
            begin
                k3_reg  <= (3 * SW)'(k2_reg) * (3 * SW)'(k_reg);
                n3_reg  <= (3 * SW)'(n2_reg) * (3 * SW)'(n_reg);
                m3_reg  <= (3 * SW)'(m2_reg) * (3 * SW)'(m);
                k2n_reg <= (3 * SW)'(k2_reg) * (3 * SW)'(n_reg);
                kn2_reg <= (3 * SW)'(n2_reg) * (3 * SW)'(k_reg);
            end
            ST_WGT:
            begin
                w_reg[0] <= WW'(m3_reg);
                w_reg[1] <= WW'(w1_full);
                w_reg[2] <= WW'(w2_full);
                w_reg[3] <= WW'(k3_reg);
                d_reg    <= WW'(6 * IW'(n3_reg));
                acc_reg  <= '0;
            end
            ST_MAC:
            begin
                // rotate so the point set is intact after four steps
                for (int a = 0; a < 3; a++)
                begin
                    acc_reg[a] <= acc_reg[a] + AW'(w_reg[0]) * AW'(u_reg[0][a]);
                end
                u_reg <= {u_reg[0], u_reg[3], u_reg[2], u_reg[1]};
                w_reg <= {w_reg[0], w_reg[3], w_reg[2], w_reg[1]};
            end
            ST_NUM:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a] <= num[a][AW:CB];
                    low_reg[a] <= num[a][CB-1:0];
                end
            end
            ST_DIV:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    rem_reg[a] <= rem_next[a];
                    low_reg[a] <= {low_reg[a][CB-2:0], 1'b0};
                    quo_reg[a] <= {quo_reg[a][CB-2:0], ge[a]};
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/bspline_curve_tessellator_top.sv
// ----------------------------------------------------------------------------
// bspline_curve_tessellator_top
// Uniform cubic B-spline curve tessellator with APB step-count register.
// ----------------------------------------------------------------------------
// Per curve point the evaluator steps through squares, cubes, weights,
//   the multiply-accumulate, the numerator and the radix-2 rounding
//   divider, then waits for room in the result queue. It takes a new
//   segment only after the last curve point of the one before is pushed.
// Reset: asynchronous, active low; queues and window empty, steps = 10.
// ----------------------------------------------------------------------------
module bspline_curve_tessellator_top #(
    parameter int MaxSteps = bct_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // control point queue side
    input  logic                               push,
    output logic                               full,
    input  bct_pkg::point_in_t                 point,
    // curve point queue side
    output logic                               empty,
    input  logic                               pop,
    output bct_pkg::curve_out_t                curve,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bct_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [bct_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [bct_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                               pready
);

    import bct_pkg::*;

    // steps per segment; to be written only while the block is idle, which the block itself does not enforce
    logic [STEPS_WIDTH-1:0] steps_reg;
    logic                   cfg_wr;

    // front -> back segment queue
    logic                   seg_push, seg_full, seg_pop, seg_empty;
    segment_t               seg_in, seg_out;

    // back -> result queue
    logic                   res_push, res_full;
    curve_out_t             res_data;

    // ------------------------------------------------------------------
    // Register file: single word, decoded on the word index bit of paddr
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_STEPS))
        begin
            steps_reg <= pwdata[STEPS_WIDTH-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_STEPS)
        begin
            prdata = DATA_WIDTH'(steps_reg);
        end
    end

    // ------------------------------------------------------------------
    // Front: keeps the last three points, hands out whole segments.
    // full follows the segment queue, so a stalled evaluator backs up
    // here only once two segments are waiting.
    // ------------------------------------------------------------------
    bct_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .point    (point),
        .seg_push (seg_push),
        .seg_data (seg_in),
        .seg_full (seg_full)
    );

    bct_fifo #(
        .Width ($bits(segment_t)),
        .Depth (SEG_FIFO_DEPTH)
    ) u_seg_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (seg_push),
        .wr_data (seg_in),
        .full    (seg_full),
        .pop     (seg_pop),
        .rd_data (seg_out),
        .empty   (seg_empty)
    );

    // ------------------------------------------------------------------
    // Back: per curve point, weights from k and n, a four-step MAC per
    // axis and a shared-control rounding divide by 6n^3.
    // ------------------------------------------------------------------
    bct_back #(
        .MaxSteps (MaxSteps)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .steps     (steps_reg),
        .seg_empty (seg_empty),
        .seg_pop   (seg_pop),
        .seg_data  (seg_out),
        .res_push  (res_push),
        .res_data  (res_data),
        .res_full  (res_full)
    );

    // result queue parts the evaluator from the consumer
    bct_fifo #(
        .Width ($bits(curve_out_t)),
        .Depth (RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .pop     (pop),
        .rd_data (curve),
        .empty   (empty)
    );

endmodule

// File: dv/bct_tessellation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_tessellation_checker
// Watches the control point, curve point and APB channels of the tessellator,
// works out the curve points each accepted control point must produce, and
// compares them field by field, in order, with what the block hands out.
// ----------------------------------------------------------------------------
module bct_tessellation_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  bct_pkg::point_in_t             point,
    input  logic                           empty,
    input  logic                           pop,
    input  bct_pkg::curve_out_t            curve,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bct_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [bct_pkg::DATA_WIDTH-1:0] pwdata,
    input  logic                           pready,
    output int                             fail_count,
    output int                             outstanding
);

    import bct_pkg::*;

    localparam logic [COORD_BITS-1:0] SIGN_BIT = {1'b1, {(COORD_BITS-1){1'b0}}};

    // coordinates kept in offset binary so the blend is all unsigned
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } biased_pt_t;

    logic [STEPS_WIDTH-1:0] steps_reg;
    biased_pt_t             window [3];
    int unsigned            window_fill;
    curve_out_t             curve_points_due [$];

    // two's complement <-> offset binary, its own inverse
    function automatic logic [COORD_BITS-1:0] rebias(input logic [COORD_BITS-1:0] v);
        return v ^ SIGN_BIT;
    endfunction

    // one axis of the cubic B-spline at t = k/steps, rounded half up
    function automatic logic [COORD_BITS-1:0] blend_axis(
        input logic [COORD_BITS-1:0] c0,
        input logic [COORD_BITS-1:0] c1,
        input logic [COORD_BITS-1:0] c2,
        input logic [COORD_BITS-1:0] c3,
        input int unsigned           steps,
        input int unsigned           k
    );
        longint unsigned n, t, m, n3, k2, k3, w0, w1, w2, w3, d, s, r;
        n  = steps;
        t  = k;
        m  = n - t;
        n3 = n * n * n;
        k2 = t * t;
        k3 = k2 * t;
        w0 = m * m * m;
        w1 = 64'd3 * k3 + 64'd4 * n3 - 64'd6 * k2 * n;
        w2 = 64'd3 * k2 * n + 64'd3 * t * n * n + n3 - 64'd3 * k3;
        w3 = k3;
        d  = 64'd6 * n3;
        s  = w0 * c0 + w1 * c1 + w2 * c2 + w3 * c3;
        r  = (64'd2 * s + d) / (64'd2 * d);
        return rebias(r[COORD_BITS-1:0]);
    endfunction

    task automatic check_field(input string name, input logic [COORD_BITS-1:0] want,
                               input logic [COORD_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        biased_pt_t  cur;
        curve_out_t  due;
        int unsigned n;
        if (!rst_n)
        begin
            steps_reg   = STEPS_RESET;
            window      = '{default: '0};
            window_fill = 0;
            curve_points_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_WIDTH-1:2] == REG_STEPS)
                steps_reg = pwdata[STEPS_WIDTH-1:0];

            if (pop && !empty)
            begin
                if (curve_points_due.size() == 0)
                begin
                    $display("%0t: curve point with none due, expected nothing, got %h",
                             $time, curve);
                    fail_count++;
                end
                else
                begin
                    due = curve_points_due.pop_front();
                    check_field("curve_x", due.curve_x, curve.curve_x);
                    check_field("curve_y", due.curve_y, curve.curve_y);
                    check_field("curve_z", due.curve_z, curve.curve_z);
                    check_field("segment_last", COORD_BITS'(due.segment_last),
                                COORD_BITS'(curve.segment_last));
                end
            end

            if (push && !full)
            begin
                cur.x = rebias(point.point_x);
                cur.y = rebias(point.point_y);
                cur.z = rebias(point.point_z);
                // a full window means this point closes a segment
                if (window_fill == 3)
                begin
                    n = (steps_reg == 0) ? 1 : steps_reg;
                    if (n > MAX_STEPS_DEFAULT)
                        n = MAX_STEPS_DEFAULT;
                    for (int unsigned k = 0; k <= n; k++)
                    begin
                        due.curve_x = blend_axis(window[0].x, window[1].x, window[2].x,
                                                 cur.x, n, k);
                        due.curve_y = blend_axis(window[0].y, window[1].y, window[2].y,
                                                 cur.y, n, k);
                        due.curve_z = blend_axis(window[0].z, window[1].z, window[2].z,
                                                 cur.z, n, k);
                        due.segment_last = (k == n);
                        curve_points_due.push_back(due);
                    end
                end
                if (point.end_of_curve)
                begin
                    window      = '{default: '0};
                    window_fill = 0;
                end
                else
                begin
                    window[0] = window[1];
                    window[1] = window[2];
                    window[2] = cur;
                    if (window_fill < 3)
                        window_fill++;
                end
            end

            outstanding = curve_points_due.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the cubic B-spline curve tessellator: directed
// extremes and corner cases, a back-pressure burst, then random curves over
// several step settings with random idling on both queue sides.
// ----------------------------------------------------------------------------
module tb_top;
    import bct_pkg::*;

    localparam int     CLK_HALF_NS  = 5;
    localparam int     MAX_GAP      = 17;
    // covers any pointless item still in flight
    localparam int     QUIET_CYCLES = 64;
    // long enough for both internal queues to fill at two steps per segment
    localparam int     HOLD_CYCLES  = 600;
    localparam longint LIMIT_NS     = 64'd20_000_000;

    localparam logic [ADDR_WIDTH-1:0] STEPS_ADDR = {REG_STEPS, 2'b00};
    // next word up decodes to nothing; a write there must be dropped
    localparam logic [ADDR_WIDTH-1:0] SPARE_ADDR = {~REG_STEPS, 2'b00};

    localparam coord_t C_MIN = 16'sh8000;
    localparam coord_t C_MAX = 16'sh7FFF;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    point_in_t             point   = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    curve_out_t            curve;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr   = '0;
    logic [DATA_WIDTH-1:0] pwdata  = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    int fail_count;
    int outstanding;

    // idling switches, flipped per phase by the stimulus process
    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    bspline_curve_tessellator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .point   (point),
        .empty   (empty),
        .pop     (pop),
        .curve   (curve),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bct_tessellation_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .point       (point),
        .empty       (empty),
        .pop         (pop),
        .curve       (curve),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #LIMIT_NS;
        $display("FAIL bspline_curve_tessellator_top");
        $finish;
    end

    // --------------------------------------------------------------------
    // Helpers. All of them are entered and left in the time step of a
    // rising edge, so every drive lands as a nonblocking update there.
    // --------------------------------------------------------------------

    // APB write: setup cycle, then access until pready
    task automatic write_reg(input logic [ADDR_WIDTH-1:0] addr,
                             input logic [DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // only the low bits hold the step count; the rest get noise
    task automatic set_steps(input int unsigned steps);
        logic [DATA_WIDTH-1:0] wd;
        wd = $urandom;
        wd[STEPS_WIDTH-1:0] = steps[STEPS_WIDTH-1:0];
        write_reg(STEPS_ADDR, wd);
    endtask

    // Offer one item and return at the edge that takes it. push is left
    // high, so a follow-on item with no gap goes out back to back.
    task automatic send_point(input point_in_t p);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        point <= p;
        do @(posedge clk); while (full);
    endtask

    function automatic point_in_t mk_point(input coord_t x, input coord_t y, input coord_t z,
                                           input logic last);
        point_in_t p;
        p.point_x      = x;
        p.point_y      = y;
        p.point_z      = z;
        p.end_of_curve = last;
        return p;
    endfunction

    // mostly uniform, with the range ends thrown in now and then
    function automatic coord_t rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0:       return C_MIN;
            1:       return C_MAX;
            default: return r[COORD_BITS-1:0];
        endcase
    endfunction

    function automatic point_in_t rand_point(input logic last);
        return mk_point(rand_coord(), rand_coord(), rand_coord(), last);
    endfunction

    // Stop offering, wait for every curve point due, then let the block go
    // quiet so the register can be touched safely.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Mostly whole curves of four to ten points; the rest is short runs
    // with random end flags, which leave stray points in the window or
    // cut a curve off before it gets going.
    task automatic random_phase(input int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(4, 10);
                for (int i = 0; i < len; i++)
                    send_point(rand_point(i == len - 1));
            end
            else
            begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_point(rand_point(1'($urandom_range(0, 1))));
            end
            sent += len;
        end
    endtask

    // --------------------------------------------------------------------
    // Result side: a random wait before each item, none when idling is off,
    // and one long hold-off on request.
    // --------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned gap;
        bit          held_once;
        held_once = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req && !held_once)
            begin
                held_once = 1'b1;
                gap = HOLD_CYCLES;
            end
            else if (rx_idle_en)
                gap = $urandom_range(0, MAX_GAP);
            else
                gap = 0;
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // --------------------------------------------------------------------
    // Main stimulus
    // --------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned steps;
        int          items;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset step count of ten. Four extreme points close one segment
        // and the end flag on the fourth clears the window.
        send_point(mk_point(C_MIN, C_MIN, C_MIN, 1'b0));
        send_point(mk_point(C_MAX, C_MAX, C_MAX, 1'b0));
        send_point(mk_point(C_MIN, C_MAX, 16'sh0000, 1'b0));
        send_point(mk_point(C_MAX, C_MIN, -16'sh0001, 1'b1));
        // a lone point with end set: nothing comes out
        send_point(mk_point(16'sh0001, -16'sh0001, C_MAX, 1'b1));
        // three points then end: window never fills
        send_point(mk_point(C_MAX, 16'sh0000, C_MIN, 1'b0));
        send_point(mk_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
        send_point(mk_point(-16'sh0100, 16'sh0100, 16'sh0080, 1'b1));
        // alternating extremes, two segments back to back
        send_point(mk_point(C_MAX, C_MIN, C_MAX, 1'b0));
        send_point(mk_point(C_MIN, C_MAX, C_MIN, 1'b0));
        send_point(mk_point(C_MAX, C_MIN, C_MAX, 1'b0));
        send_point(mk_point(C_MIN, C_MAX, C_MIN, 1'b0));
        send_point(mk_point(16'sh0001, 16'sh0002, 16'sh0003, 1'b1));
        settle();

        // zero steps behaves as one
        set_steps(0);
        for (int i = 0; i < 5; i++)
            send_point(rand_point(i == 4));
        settle();

        // largest step count
        set_steps(MAX_STEPS_DEFAULT);
        for (int i = 0; i < 5; i++)
            send_point(rand_point(i == 4));
        settle();

        // one step, then a write to an unmapped word that must not stick
        set_steps(1);
        write_reg(SPARE_ADDR, 32'h0000_0007);
        for (int i = 0; i < 4; i++)
            send_point(rand_point(i == 3));
        settle();

        // Back-pressure: the sink sits out a long stretch while points keep
        // coming with no gaps, so both internal queues fill and full rises.
        set_steps(2);
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_point(rand_point(i == 39));
        settle();

        // Random curves over a spread of step counts; one short phase at the
        // top step count, the rest small. Idling varies by phase.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                steps = MAX_STEPS_DEFAULT;
                items = 8;
            end
            else
            begin
                steps = $urandom_range(0, 9);
                items = 45;
            end
            case ($urandom_range(0, 5))
                0:       {tx_idle_en, rx_idle_en} = 2'b00;
                1:       {tx_idle_en, rx_idle_en} = 2'b10;
                2:       {tx_idle_en, rx_idle_en} = 2'b01;
                default: {tx_idle_en, rx_idle_en} = 2'b11;
            endcase
            set_steps(steps);
            random_phase(items);
            settle();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS bspline_curve_tessellator_top");
        else
            $display("FAIL bspline_curve_tessellator_top");
        $finish;
    end

endmodule
